### hdl/triangle_path_edge_walker_assert.svh
// Assertion macros for the triangle path edge walker.
// Included by the walker module, which carries the concurrent checks; no other dependencies.
`ifndef TRIANGLE_PATH_EDGE_WALKER_ASSERT_SVH
`define TRIANGLE_PATH_EDGE_WALKER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TPEW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpew check failed");

// Next-cycle implication, disabled in reset.
`define TPEW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpew check failed");

`endif

### hdl/tpew_pkg.sv
// Shared types, codes and geometry constants for the triangle path edge walker.
// No dependencies.
package tpew_pkg;

  localparam int POS_FRAC_BITS = 4;

  localparam int MUL_W    = 33;
  localparam int PROD_W   = 48;
  localparam int COORD_W  = 48;
  localparam int SCALED_W = COORD_W + POS_FRAC_BITS + 1;
  localparam int RND_SHIFT = 33;
  localparam int WIDE_W   = SCALED_W - RND_SHIFT;
  localparam int W_W      = 14;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;
  localparam logic [1:0] FUNC_QUERY = 2'd3;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_LEAD = 2'd1;
  localparam logic [1:0] CMD_MOVE = 2'd2;
  localparam logic [1:0] CMD_HOME = 2'd3;

  localparam logic CFG_SPEED = 1'b0;
  localparam logic CFG_HOLD  = 1'b1;

  localparam logic [9:0]  SPEED_RESET = 10'd75;
  localparam logic [15:0] HOLD_RESET  = 16'd200;

  localparam logic [16:0] FRAC_ONE    = 17'h10000;
  localparam logic [31:0] MIN_TICK_MS = 32'd5;
  localparam logic [16:0] COS30_Q16   = 17'd56756;

  // floor(w / 5) == (w * 52429) >> 18 for every w below 2^18
  localparam logic [15:0] DIV5_RECIP = 16'd52429;
  localparam int          DIV5_SHIFT = 18;
  localparam logic [W_W-1:0] SAT_LIMIT = 14'd10240;

  // Rotation offsets in tenths of a mm scaled by 2^32
  localparam logic signed [COORD_W-1:0] RX_BASE = 48'sd3347605094400;
  localparam logic signed [COORD_W-1:0] RY_BASE = -48'sd1932735283200;
  localparam logic [SCALED_W-1:0] RND_HALF = SCALED_W'(64'd21474836480);

  typedef struct packed {
    logic           neg;
    logic           sat;
    logic [W_W-1:0] w;
  } fmt_t;

  function automatic logic [1:0] next_edge(input logic [1:0] e);
    logic [1:0] n;
    unique case (e)
      2'd0:    n = 2'd1;
      2'd1:    n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [19:0] edge_recip(input logic [1:0] e);
    logic [19:0] r;
    unique case (e)
      2'd1:    r = 20'd897121;
      default: r = 20'd897502;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] vtx_y(input logic [1:0] e);
    logic signed [15:0] v;
    unique case (e)
      2'd0:    v = -16'sd20;
      2'd1:    v = -16'sd403;
      default: v = 16'sd363;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] vtx_z(input logic [1:0] e);
    logic signed [15:0] v;
    unique case (e)
      2'd0:    v = 16'sd1022;
      default: v = 16'sd359;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] edge_dy(input logic [1:0] e);
    logic signed [15:0] v;
    unique case (e)
      2'd1:    v = 16'sd766;
      default: v = -16'sd383;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] edge_dz(input logic [1:0] e);
    logic signed [15:0] v;
    unique case (e)
      2'd0:    v = -16'sd663;
      2'd1:    v = 16'sd0;
      default: v = 16'sd663;
    endcase
    return v;
  endfunction

endpackage

### hdl/tpew_mul.sv
// Shared signed multiplier with a registered product.
// Depends on tpew_pkg for operand and product widths.
module tpew_mul (
  input  logic                                clk_i,
  input  logic signed [tpew_pkg::MUL_W-1:0]   a_i,
  input  logic signed [tpew_pkg::MUL_W-1:0]   b_i,
  output logic signed [tpew_pkg::PROD_W-1:0]  p_o
);

  logic signed [2*tpew_pkg::MUL_W-1:0] full;
  logic signed [tpew_pkg::PROD_W-1:0]  p_q;

  assign full = a_i * b_i;

  // every product used by the sequencer fits the kept width
  always_ff @(posedge clk_i) begin
    p_q <= full[tpew_pkg::PROD_W-1:0];
  end

  assign p_o = p_q;

endmodule

### hdl/tpew_fmt.sv
// Output coordinate prescale: magnitude, rounding offset, coarse shift, saturation flag.
// Depends on tpew_pkg for widths and the fmt_t struct.
module tpew_fmt (
  input  logic signed [tpew_pkg::COORD_W-1:0] coord_i,
  output tpew_pkg::fmt_t                      fmt_o
);

  logic [tpew_pkg::COORD_W-1:0]  mag;
  logic [tpew_pkg::SCALED_W-1:0] scaled;
  logic [tpew_pkg::WIDE_W-1:0]   wide;

  always_comb begin
    mag    = coord_i[tpew_pkg::COORD_W-1] ? tpew_pkg::COORD_W'(-coord_i)
                                          : tpew_pkg::COORD_W'(coord_i);
    scaled = (tpew_pkg::SCALED_W'(mag) << tpew_pkg::POS_FRAC_BITS) + tpew_pkg::RND_HALF;
    // divide by 2^33 here, the remaining divide by 5 goes through the multiplier
    wide   = scaled[tpew_pkg::SCALED_W-1:tpew_pkg::RND_SHIFT];
    fmt_o.neg = coord_i[tpew_pkg::COORD_W-1];
    fmt_o.sat = wide >= tpew_pkg::WIDE_W'(tpew_pkg::SAT_LIMIT);
    fmt_o.w   = wide[tpew_pkg::W_W-1:0];
  end

endmodule

### hdl/triangle_path_edge_walker.sv
// A moving tick runs DEC, M1-M5, PT0-PT3, F0-F3 and EMIT; start goes from DEC to PT0,
// stop and status query go from DEC to EMIT; ticks that produce no result end at DEC.
// One item at a time: the next is accepted only after the previous returns to idle;
// this is set by the single shared multiplier used for every product in sequence.
// Reset (async, active low) clears all walker state and loads speed 75 mm/s, hold 200 ms.
`include "triangle_path_edge_walker_assert.svh"

module triangle_path_edge_walker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] now_ms_i,
  input  logic        planner_idle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  command_o,
  output logic signed [11:0] pos_x_o,
  output logic signed [11:0] pos_y_o,
  output logic signed [11:0] pos_z_o,
  output logic        running_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_M3   = 4'd4;
  localparam logic [3:0] S_M4   = 4'd5;
  localparam logic [3:0] S_M5   = 4'd6;
  localparam logic [3:0] S_PT0  = 4'd7;
  localparam logic [3:0] S_PT1  = 4'd8;
  localparam logic [3:0] S_PT2  = 4'd9;
  localparam logic [3:0] S_PT3  = 4'd10;
  localparam logic [3:0] S_F0   = 4'd11;
  localparam logic [3:0] S_F1   = 4'd12;
  localparam logic [3:0] S_F2   = 4'd13;
  localparam logic [3:0] S_F3   = 4'd14;
  localparam logic [3:0] S_EMIT = 4'd15;

  // control and walker state
  logic [3:0]  state_q, state_d;
  logic        active_q, active_d;
  logic        lead_q, lead_d;
  logic        dwell_q, dwell_d;
  logic [1:0]  edge_q, edge_d;
  logic [16:0] frac_q, frac_d;
  logic [31:0] last_q, last_d;
  logic [31:0] dwell_start_q, dwell_start_d;
  logic [9:0]  speed_q;
  logic [15:0] hold_q;
  logic        out_valid_q, out_valid_d;

  // item payload and datapath
  logic [1:0]  func_q;
  logic [31:0] now_q;
  logic        idle_q;
  logic [31:0] dt_q;
  logic [29:0] sr_q;
  logic [63:0] acc_q;
  logic [1:0]  e_q;
  logic [16:0] t_q;
  logic signed [31:0] ym_q, zm_q;
  logic signed [tpew_pkg::COORD_W-1:0] cx_q, cy_q, cz_q;
  tpew_pkg::fmt_t fmtr_q;
  logic [1:0]  res_cmd_q;
  logic signed [11:0] px_q, py_q, pz_q;
  logic [1:0]  out_cmd_q;
  logic signed [11:0] out_x_q, out_y_q, out_z_q;
  logic        out_run_q;

  logic        in_accept;
  logic        out_load;
  logic [31:0] dt;
  logic [31:0] held;
  logic [43:0] step_sum;
  logic [16:0] step_t;
  logic        step_end;
  logic signed [tpew_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [tpew_pkg::PROD_W-1:0] prod;
  logic signed [tpew_pkg::COORD_W-1:0] fmt_in;
  tpew_pkg::fmt_t fmt_out;
  logic [10:0] quot;
  logic signed [11:0] fin;

  tpew_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  tpew_fmt u_fmt (
    .coord_i (fmt_in),
    .fmt_o   (fmt_out)
  );

  assign in_stall_o  = state_q != S_IDLE;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign dt   = now_q - last_q;
  assign held = now_q - dwell_start_q;

  // fraction update from the accumulated speed * dt * recip
  assign step_sum = 44'(frac_q) + acc_q[63:20];
  assign step_end = |step_sum[43:16];
  assign step_t   = step_end ? tpew_pkg::FRAC_ONE : step_sum[16:0];

  // finish one coordinate: quotient by 5, sign, clamp
  assign quot = prod[tpew_pkg::DIV5_SHIFT+10:tpew_pkg::DIV5_SHIFT];
  always_comb begin
    priority if (fmtr_q.sat) begin
      fin = fmtr_q.neg ? -12'sd2048 : 12'sd2047;
    end else if (fmtr_q.neg) begin
      fin = -$signed({1'b0, quot});
    end else begin
      fin = $signed({1'b0, quot});
    end
  end

  always_comb begin
    state_d       = state_q;
    active_d      = active_q;
    lead_d        = lead_q;
    dwell_d       = dwell_q;
    edge_d        = edge_q;
    frac_d        = frac_q;
    last_d        = last_q;
    dwell_start_d = dwell_start_q;
    out_load      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    fmt_in        = cx_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        unique case (func_q)
          tpew_pkg::FUNC_START: begin
            active_d = 1'b1;
            edge_d   = 2'd0;
            frac_d   = '0;
            dwell_d  = 1'b0;
            last_d   = now_q;
            lead_d   = 1'b1;
            state_d  = S_PT0;
          end
          tpew_pkg::FUNC_STOP: begin
            active_d = 1'b0;
            state_d  = S_EMIT;
          end
          tpew_pkg::FUNC_QUERY: begin
            state_d = S_EMIT;
          end
          default: begin
            state_d = S_IDLE;
            priority if (!active_q) begin
              state_d = S_IDLE;
            end else if (lead_q) begin
              if (idle_q) begin
                lead_d = 1'b0;
                last_d = now_q;
              end
            end else if (dt >= tpew_pkg::MIN_TICK_MS) begin
              last_d = now_q;
              if (dwell_q) begin
                if (held >= 32'(hold_q)) begin
                  dwell_d = 1'b0;
                  edge_d  = tpew_pkg::next_edge(edge_q);
                  frac_d  = '0;
                end
              end else begin
                state_d = S_M1;
              end
            end else begin
              // drop a tick that comes too soon
              state_d = S_IDLE;
            end
          end
        endcase
      end
      S_M1: begin
        mul_a   = tpew_pkg::MUL_W'(speed_q);
        mul_b   = tpew_pkg::MUL_W'(tpew_pkg::edge_recip(edge_q));
        state_d = S_M2;
      end
      S_M2: begin
        mul_a   = tpew_pkg::MUL_W'(prod[29:0]);
        mul_b   = tpew_pkg::MUL_W'(dt_q[15:0]);
        state_d = S_M3;
      end
      S_M3: begin
        mul_a   = tpew_pkg::MUL_W'(sr_q);
        mul_b   = tpew_pkg::MUL_W'(dt_q[31:16]);
        state_d = S_M4;
      end
      S_M4: begin
        state_d = S_M5;
      end
      S_M5: begin
        frac_d = step_t;
        if (step_end) begin
          dwell_d       = 1'b1;
          dwell_start_d = now_q;
        end
        state_d = S_PT0;
      end
      S_PT0: begin
        mul_a   = tpew_pkg::MUL_W'(tpew_pkg::edge_dy(e_q));
        mul_b   = tpew_pkg::MUL_W'(t_q);
        state_d = S_PT1;
      end
      S_PT1: begin
        mul_a   = tpew_pkg::MUL_W'(tpew_pkg::edge_dz(e_q));
        mul_b   = tpew_pkg::MUL_W'(t_q);
        state_d = S_PT2;
      end
      S_PT2: begin
        mul_a   = tpew_pkg::MUL_W'(ym_q);
        mul_b   = tpew_pkg::MUL_W'(tpew_pkg::COS30_Q16);
        state_d = S_PT3;
      end
      S_PT3: begin
        state_d = S_F0;
      end
      S_F0: begin
        fmt_in  = cx_q;
        mul_a   = tpew_pkg::MUL_W'(fmt_out.w);
        mul_b   = tpew_pkg::MUL_W'(tpew_pkg::DIV5_RECIP);
        state_d = S_F1;
      end
      S_F1: begin
        fmt_in  = cy_q;
        mul_a   = tpew_pkg::MUL_W'(fmt_out.w);
        mul_b   = tpew_pkg::MUL_W'(tpew_pkg::DIV5_RECIP);
        state_d = S_F2;
      end
      S_F2: begin
        fmt_in  = cz_q;
        mul_a   = tpew_pkg::MUL_W'(fmt_out.w);
        mul_b   = tpew_pkg::MUL_W'(tpew_pkg::DIV5_RECIP);
        state_d = S_F3;
      end
      S_F3: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        // hold the result until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      active_q      <= 1'b0;
      lead_q        <= 1'b0;
      dwell_q       <= 1'b0;
      edge_q        <= 2'd0;
      frac_q        <= '0;
      last_q        <= '0;
      dwell_start_q <= '0;
      speed_q       <= tpew_pkg::SPEED_RESET;
      hold_q        <= tpew_pkg::HOLD_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      active_q      <= active_d;
      lead_q        <= lead_d;
      dwell_q       <= dwell_d;
      edge_q        <= edge_d;
      frac_q        <= frac_d;
      last_q        <= last_d;
      dwell_start_q <= dwell_start_d;
      out_valid_q   <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          tpew_pkg::CFG_SPEED: speed_q <= cfg_data_i[9:0];
          tpew_pkg::CFG_HOLD:  hold_q  <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          func_q <= func_i;
          now_q  <= now_ms_i;
          idle_q <= planner_idle_i;
        end
      end
      S_DEC: begin
        dt_q <= dt;
        e_q  <= (func_q == tpew_pkg::FUNC_START) ? 2'd0 : edge_q;
        t_q  <= '0;
        px_q <= '0;
        py_q <= '0;
        pz_q <= '0;
        unique case (func_q)
          tpew_pkg::FUNC_START: res_cmd_q <= tpew_pkg::CMD_LEAD;
          tpew_pkg::FUNC_STOP:  res_cmd_q <= tpew_pkg::CMD_HOME;
          tpew_pkg::FUNC_QUERY: res_cmd_q <= tpew_pkg::CMD_NONE;
          default:              res_cmd_q <= tpew_pkg::CMD_MOVE;
        endcase
      end
      S_M2: sr_q <= prod[29:0];
      S_M3: acc_q <= 64'(prod[45:0]);
      S_M4: acc_q <= acc_q + {prod, 16'b0};
      S_M5: t_q <= step_t;
      S_PT1: ym_q <= (32'(tpew_pkg::vtx_y(e_q)) <<< 16) + prod[31:0];
      S_PT2: zm_q <= (32'(tpew_pkg::vtx_z(e_q)) <<< 16) + prod[31:0];
      S_PT3: begin
        cx_q <= tpew_pkg::RX_BASE + (tpew_pkg::COORD_W'(ym_q) <<< 15);
        cy_q <= tpew_pkg::RY_BASE + prod;
        cz_q <= tpew_pkg::COORD_W'(zm_q) <<< 16;
      end
      S_F0: fmtr_q <= fmt_out;
      S_F1: begin
        fmtr_q <= fmt_out;
        px_q   <= fin;
      end
      S_F2: begin
        fmtr_q <= fmt_out;
        py_q   <= fin;
      end
      S_F3: pz_q <= fin;
      default: begin
      end
    endcase
    if (out_load) begin
      out_cmd_q <= res_cmd_q;
      out_x_q   <= px_q;
      out_y_q   <= py_q;
      out_z_q   <= pz_q;
      out_run_q <= active_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign command_o   = out_cmd_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign pos_z_o     = out_z_q;
  assign running_o   = out_run_q;

  `TPEW_ASSERT_NOW(a_dwell_at_end, clk_i, rst_ni, dwell_q, frac_q == tpew_pkg::FRAC_ONE)
  `TPEW_ASSERT_NOW(a_lead_not_dwelling, clk_i, rst_ni, lead_q, !dwell_q)
  `TPEW_ASSERT_NEXT(a_accept_starts_work, clk_i, rst_ni, in_accept, state_q == S_DEC)
  `TPEW_ASSERT_NOW(a_home_not_running, clk_i, rst_ni,
    (state_q == S_EMIT) && (res_cmd_q == tpew_pkg::CMD_HOME), !active_q)

endmodule
